/* design/olde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olde_pkg: shared types for the ordered list deque engine
// Request kinds, result status codes, sequencer states and the ring
// store command struct.
// ----------------------------------------------------------------------------
package olde_pkg;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned FOUND_W     = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_REM_FRONT = 3'd2,
    KIND_SEARCH    = 3'd3,
    KIND_REM_POS   = 3'd4,
    KIND_PEEK      = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic we;       // write this cycle
    logic at_prev;  // write at the slot before the head instead of the offset slot
  } ring_cmd_t;

endpackage

/* design/ordered_list_deque_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_deque_engine_unit: ordered list / deque of signed 32-bit values
// Ring store addressed from a head index; a sequencer walks the store one
// entry at a time through a single read port for search and gap closing.
// ----------------------------------------------------------------------------
// Inserts and failed requests go straight to the result; remove front and peek
// fetch the head entry first; search reads and compares one entry per step;
// remove at position fetches the entry, then reads and writes each later one.
// One request at a time, the next taken the cycle after the result transaction;
// the single memory port (one registered read and one write per cycle) gives each
// walked entry a read state before its compare or write state. Reset clears head index and count; no store clear.
module ordered_list_deque_engine_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] value, [39:32] position
  input  logic [olde_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] kind
  input  logic [olde_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] data, [39:32] found_position, [41:40] status, [50:42] count
  output logic [olde_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import olde_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e                    state_q, state_d;
  logic [IW-1:0]             head_q, head_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             idx_q, idx_d;
  kind_e                     kind_q, kind_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic signed [VALUE_W-1:0] data_q, data_d;
  logic [FOUND_W-1:0]        found_q, found_d;
  status_e                   status_q, status_d;

  kind_e                     in_kind;
  logic [VALUE_W-1:0]        in_value;
  logic [POS_W-1:0]          in_pos;

  ring_cmd_t                 ring_cmd;
  logic [CW-1:0]             ring_off;
  logic [VALUE_W-1:0]        ring_wdata;
  logic [VALUE_W-1:0]        ring_rdata;
  logic [IW-1:0]             head_prev;
  logic [IW-1:0]             head_next;

  logic                      full, empty, pos_bad, match;
  logic [CW:0]               idx1, idx2, cnt1;

  assign in_kind  = kind_e'(s_axis_tuser[KIND_W-1:0]);
  assign in_value = s_axis_tdata[VALUE_W-1:0];
  assign in_pos   = s_axis_tdata[VALUE_W+POS_W-1:VALUE_W];

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign pos_bad   = (PW'(in_pos) >= PW'(count_q));
  assign match     = (ring_rdata == value_q);
  assign idx1      = (CW+1)'(idx_q) + (CW+1)'(1);
  assign idx2      = (CW+1)'(idx_q) + (CW+1)'(2);
  assign cnt1      = (CW+1)'(count_q);
  assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);

  olde_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .cmd_i       (ring_cmd),
    .head_i      (head_q),
    .off_i       (ring_off),
    .wdata_i     (ring_wdata),
    .rdata_o     (ring_rdata),
    .head_prev_o (head_prev)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_kind)
            KIND_INS_FRONT, KIND_INS_BACK: state_d = ST_RESP;
            KIND_REM_FRONT, KIND_PEEK:     state_d = empty ? ST_RESP : ST_FETCH;
            KIND_SEARCH:                   state_d = empty ? ST_RESP : ST_SRCH_RD;
            KIND_REM_POS:  state_d = (empty || pos_bad) ? ST_RESP : ST_FETCH;
            default:                       state_d = ST_RESP;
          endcase
        end
      end
      ST_FETCH: begin
        state_d = (kind_q == KIND_REM_POS && idx1 < cnt1) ? ST_SHIFT_RD : ST_RESP;
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = (match || idx1 >= cnt1) ? ST_RESP : ST_SRCH_RD;
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = (idx2 >= cnt1) ? ST_RESP : ST_SHIFT_RD;
      ST_RESP: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    kind_d     = kind_q;
    value_d    = value_q;
    data_d     = data_q;
    found_d    = found_q;
    status_d   = status_q;
    ring_cmd   = '0;
    ring_off   = idx_q;
    ring_wdata = ring_rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d   = in_kind;
          value_d  = in_value;
          data_d   = '0;
          found_d  = '0;
          status_d = STAT_OK;
          idx_d    = '0;
          case (in_kind)
            KIND_INS_FRONT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ring_cmd.we      = 1'b1;
                ring_cmd.at_prev = 1'b1;
                ring_wdata       = in_value;
                head_d           = head_prev;
                count_d          = count_q + CW'(1);
              end
            end
            KIND_INS_BACK: begin
              ring_off = count_q;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ring_cmd.we = 1'b1;
                ring_wdata  = in_value;
                count_d     = count_q + CW'(1);
              end
            end
            KIND_REM_FRONT, KIND_PEEK, KIND_SEARCH: begin
              ring_off = '0;
              if (empty) begin
                status_d = STAT_EMPTY;
              end
            end
            KIND_REM_POS: begin
              ring_off = CW'(in_pos);
              idx_d    = CW'(in_pos);
              if (empty) begin
                status_d = STAT_EMPTY;
              end else if (pos_bad) begin
                status_d = STAT_MISS;
              end
            end
            default: status_d = STAT_MISS;
          endcase
        end
      end
      ST_FETCH: begin
        data_d = ring_rdata;
        if (kind_q == KIND_REM_FRONT) begin
          head_d  = head_next;
          count_d = count_q - CW'(1);
        end else if (kind_q == KIND_REM_POS && idx1 >= cnt1) begin
          count_d = count_q - CW'(1);
        end
      end
      ST_SRCH_RD: ring_off = idx_q;
      ST_SRCH_CMP: begin
        if (match) begin
          found_d = FOUND_W'(idx_q);
        end else if (idx1 >= cnt1) begin
          status_d = STAT_MISS;
        end else begin
          idx_d = CW'(idx1);
        end
      end
      ST_SHIFT_RD: ring_off = CW'(idx1);
      ST_SHIFT_WR: begin
        // move entry i+1 down into slot i
        ring_off    = idx_q;
        ring_cmd.we = 1'b1;
        ring_wdata  = ring_rdata;
        idx_d       = CW'(idx1);
        if (idx2 >= cnt1) begin
          count_d = count_q - CW'(1);
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    kind_q   <= kind_d;
    value_q  <= value_d;
    data_q   <= data_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_RESP);
  assign m_axis_tdata  = {5'b0, COUNT_W'(count_q), status_q, found_q, data_q};

  // count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // a full status is only reported on a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q == STAT_FULL) |-> full)
    else $error("full status with free entries");

  // walking the store never moves the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_CMP || state_q == ST_SHIFT_WR) |=> $stable(head_q))
    else $error("head moved during walk");

  // the input side is closed while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

endmodule

/* design/olde_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olde_ring: ring store with shared slot address unit
// Maps a list offset to a ring slot relative to the head, holds the entry
// memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module olde_ring #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                clk_i,
  input  olde_pkg::ring_cmd_t                 cmd_i,
  input  logic [$clog2(DEPTH)-1:0]            head_i,
  input  logic [$clog2(DEPTH+1)-1:0]          off_i,
  input  logic [olde_pkg::VALUE_W-1:0]        wdata_i,
  output logic [olde_pkg::VALUE_W-1:0]        rdata_o,
  output logic [$clog2(DEPTH)-1:0]            head_prev_o
);
  import olde_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [SW-1:0]      sum;
  logic [IW-1:0]      slot;
  logic [IW-1:0]      waddr;
  logic [VALUE_W-1:0] rdata_q;

  // head + offset, folded once into the ring (sum stays below twice DEPTH)
  always_comb begin
    sum = SW'(head_i) + SW'(off_i);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    slot = sum[IW-1:0];
  end

  assign head_prev_o = (head_i == '0) ? IW'(DEPTH - 1) : head_i - IW'(1);
  assign waddr       = cmd_i.at_prev ? head_prev_o : slot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[slot];
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb_ordered_list_deque_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_deque_engine_unit: self-checking bench for the list engine
// A queue of requests feeds a clocked stream driver. Each accepted request
// is run through a local model of the ring list, and the expected response
// is queued. A clocked monitor compares every response field by field.
// Stimulus: directed corner cases, then mixed random traffic with a fill to
// full and a drain to empty, under three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_ordered_list_deque_engine_unit;
  import olde_pkg::*;

  localparam int LIST_DEPTH   = 256;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 600;

  // Kind codes that carry no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } list_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [FOUND_W-1:0] found_pos;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } list_resp_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  ordered_list_deque_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Local copy of the ring list
  logic [VALUE_W-1:0] ring_mem [LIST_DEPTH];
  logic [POS_W-1:0]   ring_head;
  int                 ring_count;

  list_req_t  req_q[$];
  list_resp_t expected_resp_q[$];
  list_req_t  cur_req;

  int gen_cnt;
  int phase1_start;
  int phase2_start;
  int n_issued;
  int n_accepted;
  int n_received;
  int n_full_seen;
  int n_empty_seen;
  int n_miss_seen;
  int errors;
  int stall_cycles;

  function automatic list_resp_t deque_apply(list_req_t r);
    list_resp_t rsp;
    int         i;
    rsp.data      = '0;
    rsp.found_pos = '0;
    rsp.status    = STAT_OK;
    case (r.kind)
      KIND_INS_FRONT: begin
        if (ring_count >= LIST_DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          ring_head           = ring_head - 8'd1;
          ring_mem[ring_head] = r.value;
          ring_count++;
        end
      end
      KIND_INS_BACK: begin
        if (ring_count >= LIST_DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          ring_mem[ring_head + 8'(ring_count)] = r.value;
          ring_count++;
        end
      end
      KIND_REM_FRONT: begin
        if (ring_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          rsp.data  = ring_mem[ring_head];
          ring_head = ring_head + 8'd1;
          ring_count--;
        end
      end
      KIND_SEARCH: begin
        if (ring_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          rsp.status = STAT_MISS;
          for (i = 0; i < ring_count; i++) begin
            if (ring_mem[ring_head + 8'(i)] == r.value) begin
              rsp.found_pos = 8'(i);
              rsp.status    = STAT_OK;
              break;
            end
          end
        end
      end
      KIND_REM_POS: begin
        if (ring_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else if (int'(r.position) >= ring_count) begin
          rsp.status = STAT_MISS;
        end else begin
          rsp.data = ring_mem[ring_head + r.position];
          // close the gap by pulling later entries forward
          for (i = int'(r.position); i + 1 < ring_count; i++) begin
            ring_mem[ring_head + 8'(i)] = ring_mem[ring_head + 8'(i + 1)];
          end
          ring_count--;
        end
      end
      KIND_PEEK: begin
        if (ring_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          rsp.data = ring_mem[ring_head];
        end
      end
      default: begin
        rsp.status = STAT_MISS;
      end
    endcase
    rsp.count = 9'(ring_count);
    return rsp;
  endfunction

  // Idle percentages per phase: receiver-heavy stalls first, then sender, then none
  function automatic int send_idle_pct(int idx);
    if (idx < phase1_start) return 8;
    if (idx < phase2_start) return 54;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int idx);
    if (idx < phase1_start) return 54;
    if (idx < phase2_start) return 8;
    return 0;
  endfunction

  task automatic push_req(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                          input logic [POS_W-1:0] position);
    list_req_t r;
    r.kind     = kind;
    r.value    = value;
    r.position = position;
    req_q.push_back(r);
    // track the list size so the generator can aim positions and fills
    case (kind)
      KIND_INS_FRONT, KIND_INS_BACK: if (gen_cnt < LIST_DEPTH) gen_cnt++;
      KIND_REM_FRONT: if (gen_cnt > 0) gen_cnt--;
      KIND_REM_POS: if (gen_cnt > 0 && int'(position) < gen_cnt) gen_cnt--;
      default: ;
    endcase
  endtask

  // Small pool of repeating values so searches hit, mixed with full-range values
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'h0000_002A;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    if (gen_cnt > 0 && $urandom_range(99) < 75) return 8'($urandom_range(gen_cnt - 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic rand_op(input int ins_weight);
    int roll;
    roll = $urandom_range(99);
    if (roll < ins_weight) begin
      push_req($urandom_range(1) ? KIND_INS_BACK : KIND_INS_FRONT, rand_value(), 8'($urandom));
    end else begin
      roll = $urandom_range(99);
      if (roll < 20)      push_req(KIND_REM_FRONT, $urandom, 8'($urandom));
      else if (roll < 50) push_req(KIND_SEARCH, rand_value(), 8'($urandom));
      else if (roll < 80) push_req(KIND_REM_POS, $urandom, rand_position());
      else if (roll < 93) push_req(KIND_PEEK, $urandom, 8'($urandom));
      else push_req($urandom_range(1) ? KIND_UNUSED_7 : KIND_UNUSED_6, $urandom, 8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: hold tvalid until accepted, bubble at random when the slot is free
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resp_q.push_back(deque_apply(cur_req));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct(n_issued)) begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.position, cur_req.value};
          s_axis_tuser  <= cur_req.kind;
          n_issued++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response transaction against the oldest expectation
  always @(posedge clk_i) begin
    list_resp_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_resp_q.size() == 0) begin
          $display("%0t ERROR unexpected response: expected none actual %0h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_resp_q.pop_front();
          check_field("data", want.data, m_axis_tdata[31:0]);
          check_field("found_position", 32'(want.found_pos), 32'(m_axis_tdata[39:32]));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[41:40]));
          check_field("count", 32'(want.count), 32'(m_axis_tdata[50:42]));
          if (want.status == STAT_FULL) n_full_seen++;
          if (want.status == STAT_EMPTY) n_empty_seen++;
          if (want.status == STAT_MISS) n_miss_seen++;
        end
        n_received++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(n_received));
    end
  end

  // Watchdog: stop when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL ordered_list_deque_engine_unit");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    ring_head     = '0;
    ring_count    = 0;
    gen_cnt       = 0;
    n_issued      = 0;
    n_accepted    = 0;
    n_received    = 0;
    n_full_seen   = 0;
    n_empty_seen  = 0;
    n_miss_seen   = 0;
    errors        = 0;
    stall_cycles  = 0;
    phase1_start  = 32'h7FFF_FFFF;
    phase2_start  = 32'h7FFF_FFFF;

    // Directed: empty list, unused kinds, extreme values, bad and edge positions
    push_req(KIND_PEEK, 32'h0, 8'h00);
    push_req(KIND_REM_FRONT, 32'h0, 8'h00);
    push_req(KIND_SEARCH, 32'h0, 8'h00);
    push_req(KIND_REM_POS, 32'h0, 8'h00);
    push_req(KIND_UNUSED_6, 32'hFFFF_FFFF, 8'hFF);
    push_req(KIND_UNUSED_7, 32'h0, 8'h00);
    push_req(KIND_INS_FRONT, 32'h8000_0000, 8'h00);
    push_req(KIND_INS_BACK, 32'h7FFF_FFFF, 8'hFF);
    push_req(KIND_INS_FRONT, 32'h0000_0000, 8'h00);
    push_req(KIND_INS_BACK, 32'hFFFF_FFFF, 8'h00);
    push_req(KIND_PEEK, 32'h0, 8'h00);
    push_req(KIND_SEARCH, 32'h7FFF_FFFF, 8'h00);
    push_req(KIND_SEARCH, 32'h1234_5678, 8'h00);
    push_req(KIND_SEARCH, 32'h8000_0000, 8'h00);
    push_req(KIND_REM_POS, 32'h0, 8'd4);
    push_req(KIND_REM_POS, 32'h0, 8'd255);
    push_req(KIND_REM_POS, 32'h0, 8'd0);
    push_req(KIND_REM_POS, 32'h0, 8'd1);
    push_req(KIND_REM_POS, 32'h0, 8'd1);
    push_req(KIND_UNUSED_7, 32'h0, 8'h00);
    push_req(KIND_REM_FRONT, 32'h0, 8'h00);
    push_req(KIND_REM_FRONT, 32'h0, 8'h00);

    repeat (40) rand_op(45);
    phase1_start = req_q.size();

    // Fill to full, probe the full list, then trim with mixed traffic
    while (gen_cnt < LIST_DEPTH) begin
      push_req($urandom_range(1) ? KIND_INS_BACK : KIND_INS_FRONT, rand_value(), 8'($urandom));
    end
    push_req(KIND_INS_FRONT, $urandom, 8'($urandom));
    push_req(KIND_INS_BACK, $urandom, 8'($urandom));
    push_req(KIND_SEARCH, rand_value(), 8'h00);
    push_req(KIND_SEARCH, $urandom, 8'h00);
    push_req(KIND_REM_POS, $urandom, 8'd255);
    push_req(KIND_REM_POS, $urandom, 8'd200);
    push_req(KIND_REM_POS, $urandom, 8'd0);
    push_req(KIND_INS_BACK, rand_value(), 8'h00);
    push_req(KIND_INS_FRONT, rand_value(), 8'h00);
    push_req(KIND_INS_BACK, rand_value(), 8'h00);
    push_req(KIND_PEEK, 32'h0, 8'h00);
    repeat (30) rand_op(30);
    phase2_start = req_q.size();

    repeat (30) rand_op(40);
    while (gen_cnt > 0) push_req(KIND_REM_FRONT, $urandom, 8'($urandom));
    push_req(KIND_REM_FRONT, $urandom, 8'($urandom));
    push_req(KIND_PEEK, $urandom, 8'($urandom));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || expected_resp_q.size() != 0) begin
      @(posedge clk_i);
    end
    // let any stray response show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests and checked %0d responses across three stall profiles",
             n_accepted, n_received);
    $display("Saw %0d full, %0d empty and %0d miss or bad-position responses",
             n_full_seen, n_empty_seen, n_miss_seen);
    if (errors == 0) begin
      $display("PASS ordered_list_deque_engine_unit");
    end else begin
      $display("FAIL ordered_list_deque_engine_unit");
    end
    $finish;
  end

endmodule
